// ===== rtl/core/hesd_pkg.sv =====
`timescale 1ns / 1ps

package hesd_pkg;

    // Characters that make up the recognized entities.
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_L     = 8'h6c;  // 'l'
    localparam logic [7:0] CH_T     = 8'h74;  // 't'
    localparam logic [7:0] CH_SEMI  = 8'h3b;  // ';'
    localparam logic [7:0] CH_G     = 8'h67;  // 'g'
    localparam logic [7:0] CH_Q     = 8'h71;  // 'q'
    localparam logic [7:0] CH_U     = 8'h75;  // 'u'
    localparam logic [7:0] CH_O     = 8'h6f;  // 'o'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_THREE = 8'h33;  // '3'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_LT    = 8'h3c;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3e;  // '>'
    localparam logic [7:0] CH_DQUOT = 8'h22;  // '"'
    localparam logic [7:0] CH_SQUOT = 8'h27;  // single quote

    // Match positions: the partial entity held so far.
    localparam logic [3:0] POS_IDLE   = 4'd0;
    localparam logic [3:0] POS_AMP    = 4'd1;   // "&"
    localparam logic [3:0] POS_L      = 4'd2;   // "&l"
    localparam logic [3:0] POS_G      = 4'd3;   // "&g"
    localparam logic [3:0] POS_LT     = 4'd4;   // "&lt"
    localparam logic [3:0] POS_GT     = 4'd5;   // "&gt"
    localparam logic [3:0] POS_Q      = 4'd6;   // "&q"
    localparam logic [3:0] POS_QU     = 4'd7;   // "&qu"
    localparam logic [3:0] POS_QUO    = 4'd8;   // "&quo"
    localparam logic [3:0] POS_QUOT   = 4'd9;   // "&quot"
    localparam logic [3:0] POS_HASH   = 4'd10;  // "&#"
    localparam logic [3:0] POS_H0     = 4'd11;  // "&#0"
    localparam logic [3:0] POS_H03    = 4'd12;  // "&#03"
    localparam logic [3:0] POS_H039   = 4'd13;  // "&#039"

    // One command from the front to the back: flush the held text of pre,
    // then an optional character, then the held text of tail.
    typedef struct packed {
        logic [3:0] pre;
        logic       has_char;
        logic [7:0] chr;
        logic [3:0] tail;
        logic       last;
    } t_cmd;

    // Number of held bytes for a match position.
    function automatic logic [2:0] f_held_len(input logic [3:0] pos);
        logic [2:0] len;
        case (pos)
            POS_AMP:                           len = 3'd1;
            POS_L, POS_G, POS_Q, POS_HASH:     len = 3'd2;
            POS_LT, POS_GT, POS_QU, POS_H0:    len = 3'd3;
            POS_QUO, POS_H03:                  len = 3'd4;
            POS_QUOT, POS_H039:                len = 3'd5;
            default:                           len = 3'd0;
        endcase
        return len;
    endfunction

    // Byte k of the held text of a match position.
    function automatic logic [7:0] f_held_byte(input logic [3:0] pos, input logic [2:0] k);
        logic [39:0] txt;
        logic [7:0]  b;
        case (pos)
            POS_AMP:  txt = {32'd0, CH_AMP};
            POS_L:    txt = {24'd0, CH_L, CH_AMP};
            POS_G:    txt = {24'd0, CH_G, CH_AMP};
            POS_LT:   txt = {16'd0, CH_T, CH_L, CH_AMP};
            POS_GT:   txt = {16'd0, CH_T, CH_G, CH_AMP};
            POS_Q:    txt = {24'd0, CH_Q, CH_AMP};
            POS_QU:   txt = {16'd0, CH_U, CH_Q, CH_AMP};
            POS_QUO:  txt = {8'd0, CH_O, CH_U, CH_Q, CH_AMP};
            POS_QUOT: txt = {CH_T, CH_O, CH_U, CH_Q, CH_AMP};
            POS_HASH: txt = {24'd0, CH_HASH, CH_AMP};
            POS_H0:   txt = {16'd0, CH_ZERO, CH_HASH, CH_AMP};
            POS_H03:  txt = {8'd0, CH_THREE, CH_ZERO, CH_HASH, CH_AMP};
            POS_H039: txt = {CH_NINE, CH_THREE, CH_ZERO, CH_HASH, CH_AMP};
            default:  txt = 40'd0;
        endcase
        case (k)
            3'd0:    b = txt[7:0];
            3'd1:    b = txt[15:8];
            3'd2:    b = txt[23:16];
            3'd3:    b = txt[31:24];
            3'd4:    b = txt[39:32];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // Byte that continues a partial entity of at least two bytes.
    function automatic logic [7:0] f_want(input logic [3:0] pos);
        logic [7:0] w;
        case (pos)
            POS_L, POS_G, POS_QUO:             w = CH_T;
            POS_LT, POS_GT, POS_QUOT, POS_H039: w = CH_SEMI;
            POS_Q:                             w = CH_U;
            POS_QU:                            w = CH_O;
            POS_HASH:                          w = CH_ZERO;
            POS_H0:                            w = CH_THREE;
            POS_H03:                           w = CH_NINE;
            default:                           w = 8'd0;
        endcase
        return w;
    endfunction

    // Position reached when the wanted byte arrives (idle when complete).
    function automatic logic [3:0] f_next(input logic [3:0] pos);
        logic [3:0] p;
        case (pos)
            POS_L:    p = POS_LT;
            POS_G:    p = POS_GT;
            POS_Q:    p = POS_QU;
            POS_QU:   p = POS_QUO;
            POS_QUO:  p = POS_QUOT;
            POS_HASH: p = POS_H0;
            POS_H0:   p = POS_H03;
            POS_H03:  p = POS_H039;
            default:  p = POS_IDLE;
        endcase
        return p;
    endfunction

    // Decoded character when ';' completes an entity, zero otherwise.
    function automatic logic [7:0] f_final(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            POS_LT:   c = CH_LT;
            POS_GT:   c = CH_GT;
            POS_QUOT: c = CH_DQUOT;
            POS_H039: c = CH_SQUOT;
            default:  c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/hesd_front.sv =====
`timescale 1ns / 1ps

module hesd_front
    import hesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic       taken;
    logic [7:0] fin;
    logic [3:0] new_pos;
    logic       accept;
    logic [3:0] out_cnt;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign fin     = f_final(r_pos);

    // Match the byte against the held partial entity.
    always_comb begin
        taken   = 1'b0;
        new_pos = POS_IDLE;
        if (r_pos == POS_AMP) begin
            taken = 1'b1;
            if (i_byte == CH_L) begin
                new_pos = POS_L;
            end else if (i_byte == CH_G) begin
                new_pos = POS_G;
            end else if (i_byte == CH_Q) begin
                new_pos = POS_Q;
            end else if (i_byte == CH_HASH) begin
                new_pos = POS_HASH;
            end else begin
                taken = 1'b0;
            end
        end else if (r_pos >= POS_L && r_pos <= POS_H039 && i_byte == f_want(r_pos)) begin
            taken   = 1'b1;
            new_pos = f_next(r_pos);
        end
        if (!taken) begin
            new_pos = (i_byte == CH_AMP) ? POS_AMP : POS_IDLE;
        end
    end

    // Build the command for the back end.
    always_comb begin
        o_cmd.pre      = taken ? POS_IDLE : r_pos;
        o_cmd.has_char = taken ? (fin != 8'd0) : (i_byte != CH_AMP);
        o_cmd.chr      = taken ? fin : i_byte;
        o_cmd.tail     = i_last ? new_pos : POS_IDLE;
        o_cmd.last     = i_last;
        out_cnt = {1'b0, f_held_len(o_cmd.pre)} + {3'd0, o_cmd.has_char}
                + {1'b0, f_held_len(o_cmd.tail)};
        n_pos   = i_last ? POS_IDLE : new_pos;
    end

    // Words that produce nothing only move the match state.
    assign o_push = accept && (out_cnt != 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_H039) else $error("match position out of range");
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |-> o_push) else $error("last word produced no output");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> r_pos == POS_IDLE) else $error("match state kept past last");

endmodule

// ===== rtl/core/hesd_fifo.sv =====
`timescale 1ns / 1ps

module hesd_fifo
    import hesd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_cmd        r_mem [DEPTH];
    logic [AW:0] r_wptr;
    logic [AW:0] r_rptr;

    assign o_empty = (r_wptr == r_rptr);
    assign o_full  = (r_wptr[AW-1:0] == r_rptr[AW-1:0]) && (r_wptr[AW] != r_rptr[AW]);
    assign o_cmd   = r_mem[r_rptr[AW-1:0]];

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr[AW-1:0]] <= i_cmd;
        end
    end

    // Pointers with a wrap bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) <= (AW+1)'(DEPTH)) else $error("queue fill count broken");

endmodule

// ===== rtl/core/hesd_back.sv =====
`timescale 1ns / 1ps

module hesd_back
    import hesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    t_cmd       r_cmd;
    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [3:0] len_pre;
    logic [3:0] len_tail;
    logic [3:0] total;
    logic [3:0] char_at;
    logic [3:0] tail_k;
    logic [7:0] cur_byte;
    logic       out_free;
    logic       advance;
    logic       at_end;

    assign len_pre  = {1'b0, f_held_len(r_cmd.pre)};
    assign len_tail = {1'b0, f_held_len(r_cmd.tail)};
    assign total    = len_pre + {3'd0, r_cmd.has_char} + len_tail;
    assign char_at  = len_pre;
    assign tail_k   = r_idx - len_pre - {3'd0, r_cmd.has_char};

    // Select the byte at the current place of the command.
    always_comb begin
        if (r_idx < len_pre) begin
            cur_byte = f_held_byte(r_cmd.pre, r_idx[2:0]);
        end else if (r_cmd.has_char && r_idx == char_at) begin
            cur_byte = r_cmd.chr;
        end else begin
            cur_byte = f_held_byte(r_cmd.tail, tail_k[2:0]);
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_busy && out_free;
    assign at_end   = (r_idx == total - 4'd1);
    assign o_pop    = !i_q_empty && (!r_busy || (advance && at_end));

    // Command register and word counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 4'd0;
        end else if (advance) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // Output register holds a word until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= cur_byte;
            r_out_last <= r_cmd.last && at_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx < total) else $error("word counter ran past command");
    a_cmd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> total != 4'd0) else $error("empty command loaded");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_byte)))
        else $error("stalled output word changed");

endmodule

// ===== rtl/core/html_entity_stream_decode.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                   Data
// s_axis    in   i_s_axis_tvalid/o_..tready  tdata[7:0] = in_byte, tlast = in_last
// m_axis    out  o_m_axis_tvalid/i_..tready  tdata[7:0] = out_byte, tlast = out_last
//
// An input word is taken every cycle while the four-entry command queue has room.
// A word expands into zero to six output words; the back end sends one per cycle
// while the sink is ready, so the sustained rate is one word per cycle except
// where held bytes are flushed. Words pass the queue, command and output registers.
// Reset is synchronous and active low and empties the queue and match state.
// Either side may stall; the queue and the output register decouple them.

module html_entity_stream_decode
    import hesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd cmd_in;
    t_cmd cmd_out;

    hesd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    hesd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (cmd_out)
    );

    hesd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (cmd_out),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hesd_pkg::*;

    // One decoded character as it should leave the block.
    typedef struct {
        logic [7:0] chr;
        logic       lst;
    } t_dec_char;

    // Tracks the partial entity, predicts the decoded text and checks the output words.
    class decode_scoreboard;
        logic [3:0] pos;
        logic [7:0] held[$];
        t_dec_char  step_out[$];
        t_dec_char  pending[$];
        int         errors;

        function new();
            pos = POS_IDLE;
            errors = 0;
        endfunction

        function void emit(input logic [7:0] b);
            t_dec_char c;
            c.chr = b;
            c.lst = 1'b0;
            step_out.push_back(c);
        endfunction

        // Held bytes go out as literal text and the match starts over.
        function void flush_held();
            foreach (held[k]) emit(held[k]);
            held.delete();
            pos = POS_IDLE;
        endfunction

        // Works out the characters that one accepted input word produces.
        function void note_word(input logic [7:0] b, input logic l);
            logic       tracked;
            logic       hit;
            logic [7:0] want;
            logic [7:0] dec;
            logic [3:0] nxt;
            tracked = 1'b1;
            hit = 1'b0;
            want = 8'h00;
            dec = 8'h00;
            nxt = POS_IDLE;

            case (pos)
                POS_L:    begin want = CH_T;     nxt = POS_LT;   end
                POS_G:    begin want = CH_T;     nxt = POS_GT;   end
                POS_LT:   begin want = CH_SEMI;  dec = CH_LT;    end
                POS_GT:   begin want = CH_SEMI;  dec = CH_GT;    end
                POS_Q:    begin want = CH_U;     nxt = POS_QU;   end
                POS_QU:   begin want = CH_O;     nxt = POS_QUO;  end
                POS_QUO:  begin want = CH_T;     nxt = POS_QUOT; end
                POS_QUOT: begin want = CH_SEMI;  dec = CH_DQUOT; end
                POS_HASH: begin want = CH_ZERO;  nxt = POS_H0;   end
                POS_H0:   begin want = CH_THREE; nxt = POS_H03;  end
                POS_H03:  begin want = CH_NINE;  nxt = POS_H039; end
                POS_H039: begin want = CH_SEMI;  dec = CH_SQUOT; end
                default:  tracked = 1'b0;
            endcase

            // After a lone ampersand, four different bytes can open an entity.
            if (pos == POS_AMP) begin
                hit = 1'b1;
                case (b)
                    CH_L:    nxt = POS_L;
                    CH_G:    nxt = POS_G;
                    CH_Q:    nxt = POS_Q;
                    CH_HASH: nxt = POS_HASH;
                    default: hit = 1'b0;
                endcase
            end else begin
                hit = tracked && (b == want);
            end

            if (hit) begin
                if (dec != 8'h00) begin
                    emit(dec);
                    held.delete();
                    pos = POS_IDLE;
                end else begin
                    held.push_back(b);
                    pos = nxt;
                end
            end else begin
                // A breaking byte is handled afresh, so it may open a new entity.
                flush_held();
                if (b == CH_AMP) begin
                    held.push_back(b);
                    pos = POS_AMP;
                end else begin
                    emit(b);
                end
            end

            // End of text: flush what is held and mark the final character.
            if (l) begin
                flush_held();
                if (step_out.size() > 0)
                    step_out[step_out.size() - 1].lst = 1'b1;
            end
            foreach (step_out[k]) pending.push_back(step_out[k]);
            step_out.delete();
        endfunction

        // Compares one output word with the oldest predicted character.
        function void check_word(input logic [7:0] b, input logic l);
            t_dec_char e;
            if (pending.size() == 0) begin
                $error("unexpected output word: out_byte %h, out_last %b", b, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (b !== e.chr) begin
                $error("out_byte mismatch: expected %h, actual %h", e.chr, b);
                errors++;
            end
            if (l !== e.lst) begin
                $error("out_last mismatch: expected %b, actual %b", e.lst, l);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       i_s_axis_tlast = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] out_byte
    logic       o_m_axis_tlast;

    decode_scoreboard sb = new();

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned sent_words = 0;
    logic [7:0]  frame_buf[$];
    logic [7:0]  ent_txt[4][6];
    int unsigned ent_len[4];
    logic [7:0]  char_set[12];
    string       amp_txt = "&amp;";

    html_entity_stream_decode i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure, drawn anew every cycle.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Both handshakes are sampled at the clock edge where they complete.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_word(i_s_axis_tdata, i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_word(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    // Offers one word, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_word(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= l;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Sends the buffered text with tlast on its final word.
    task automatic send_frame();
        foreach (frame_buf[k]) send_word(frame_buf[k], k == frame_buf.size() - 1);
        sent_words += frame_buf.size();
        frame_buf.delete();
    endtask

    // At least half of the random bytes are entity characters, so matches go deep often.
    function automatic logic [7:0] any_byte();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(255));
        return char_set[$urandom_range(11)];
    endfunction

    // A text made of whole entities, broken or cut entities, and plain bytes.
    task automatic build_random_frame();
        int unsigned kind;
        int unsigned k;
        int unsigned cut;
        repeat ($urandom_range(1, 5)) begin
            kind = $urandom_range(9);
            k = $urandom_range(3);
            if (kind <= 3) begin
                for (int i = 0; i < ent_len[k]; i++) frame_buf.push_back(ent_txt[k][i]);
            end else if (kind <= 5) begin
                cut = $urandom_range(1, ent_len[k] - 1);
                for (int i = 0; i < cut; i++) frame_buf.push_back(ent_txt[k][i]);
                if ($urandom_range(1) == 0)
                    frame_buf.push_back(any_byte());
            end else if (kind == 6) begin
                for (int i = 0; i < amp_txt.len(); i++) frame_buf.push_back(amp_txt[i]);
            end else begin
                repeat ($urandom_range(1, 3)) frame_buf.push_back(any_byte());
            end
        end
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                             input int unsigned words);
        int unsigned goal;
        goal = sent_words + words;
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        while (sent_words < goal) begin
            build_random_frame();
            send_frame();
        end
    endtask

    initial begin
        ent_txt[0] = '{CH_AMP, CH_L, CH_T, CH_SEMI, 8'h00, 8'h00};
        ent_txt[1] = '{CH_AMP, CH_G, CH_T, CH_SEMI, 8'h00, 8'h00};
        ent_txt[2] = '{CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI};
        ent_txt[3] = '{CH_AMP, CH_HASH, CH_ZERO, CH_THREE, CH_NINE, CH_SEMI};
        ent_len = '{4, 4, 6, 6};
        char_set = '{CH_AMP, CH_L, CH_T, CH_SEMI, CH_G, CH_Q, CH_U, CH_O,
                     CH_HASH, CH_ZERO, CH_THREE, CH_NINE};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero byte, then two entities, the second one completing on the final word.
        frame_buf = '{8'h00, CH_AMP, CH_G, CH_T, CH_SEMI, CH_AMP, CH_L, CH_T, CH_SEMI};
        send_frame();
        // The two longer entities back to back, then the top byte value at the end.
        frame_buf = '{CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI,
                      CH_AMP, CH_HASH, CH_ZERO, CH_THREE, CH_NINE, CH_SEMI, 8'hff};
        send_frame();
        // Longest held text broken by an ampersand on the final word: six characters out.
        frame_buf = '{CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_AMP};
        send_frame();

        run_phase(0, 0, 120);
        run_phase(61, 0, 120);
        run_phase(0, 61, 120);
        run_phase(19, 19, 120);
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
